// File: sv/assert_macros.svh
// Assertion macros shared by the RTL of the free-range table.
// No dependencies; include inside a module body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: sv/cfl_pkg.sv
// Types, codes and constants of the coalescing free-range table.
// No dependencies; used by every module of the block.
package cfl_pkg;

    localparam int ADDR_BITS   = 16;
    localparam int SIZE_W      = ADDR_BITS + 1;
    localparam int SUM_W       = SIZE_W + 1;
    localparam int ENTRIES_DEF = 64;
    localparam int IDX_W       = 6;
    localparam int TOTAL_W     = 7;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_UPDATE = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_BAD_INDEX = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH,
        S_MN,
        S_MA,
        S_MP,
        S_MB,
        S_FIN,
        S_DROP,
        S_DONE
    } t_state;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef struct packed {
        logic [1:0]           cmd;
        logic [ADDR_BITS-1:0] range_start;
        logic [SIZE_W-1:0]    range_size;
        logic [IDX_W-1:0]     entry_index;
    } t_in_item;

    typedef struct packed {
        logic [1:0]           status;
        logic [IDX_W-1:0]     slot;
        logic                 merged_next;
        logic                 merged_prev;
        logic [ADDR_BITS-1:0] result_start;
        logic [SIZE_W-1:0]    result_size;
        logic [TOTAL_W-1:0]   entry_total;
    } t_out_item;

    typedef struct packed {
        logic [ADDR_BITS-1:0] start;
        logic [SIZE_W-1:0]    size;
    } t_entry;

    typedef struct packed {
        t_alu_op           op;
        logic [SIZE_W-1:0] a;
        logic [SIZE_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic [SUM_W-1:0]  sum;
        logic [SIZE_W-1:0] sat;
    } t_alu_rsp;

endpackage

// File: sv/coalescing_free_list.sv
// Coalescing free list: sorted table of free ranges, one command at a time.
// Insert: search walks down from the top (entries above the new start are shifted up on
// the way), then merge states MN, MA, MP, MB and FIN, then compaction after a merge.
// Remove: compaction moves the entries above the index down; update, no-op and errors go straight to the result.
// Table walks go one entry a cycle through the single table read port.
// Reset empties the table (count zero); storage holds no valid state.
module coalescing_free_list #(
    parameter int ENTRIES = cfl_pkg::ENTRIES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  cfl_pkg::t_in_item  i_in_item,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output cfl_pkg::t_out_item o_out_item,
    input  logic               i_out_stall
);
    import cfl_pkg::*;
    `include "assert_macros.svh"

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int PW = $clog2(ENTRIES + 2);
    localparam int XW = (PW > IDX_W) ? PW : IDX_W;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic              r_ovalid, n_ovalid;
    t_out_item         r_oitem, n_oitem;
    logic [ADDR_BITS-1:0] r_s, n_s;
    logic [SIZE_W-1:0] r_sz, n_sz;
    logic [PW-1:0]     r_pos, n_pos;
    t_entry            r_next, n_next;
    t_entry            r_prev, n_prev;
    logic              r_hnext, n_hnext;
    logic              r_hprev, n_hprev;
    logic              r_mn, n_mn;
    logic              r_mp, n_mp;
    logic [SIZE_W-1:0] r_a, n_a;
    logic [SIZE_W-1:0] r_b, n_b;
    logic [PW-1:0]     r_rd, n_rd;
    logic [PW-1:0]     r_wr, n_wr;
    logic [PW-1:0]     r_lim, n_lim;
    logic              r_pend, n_pend;
    logic              r_cap, n_cap;
    t_out_item         r_res, n_res;

    logic          wr_en;
    logic [IW-1:0] wr_addr;
    t_entry        wr_data;
    logic [IW-1:0] rd_addr;
    t_entry        rd_data;
    t_alu_req      alu_req;
    t_alu_rsp      alu_rsp;

    t_cmd          in_cmd;
    logic          full;
    logic [XW-1:0] idx_x;
    logic [XW-1:0] cnt_x;
    logic          idx_bad;
    logic [CW-1:0] cnt_m1;
    logic [PW-1:0] pos_m1;
    logic [PW-1:0] pos_m2;
    logic          srch_gt;
    logic          srch_last;
    logic          mn_eq;
    logic          mp_eq;
    logic          drop_issue;
    logic          drop_done;
    logic          out_free;

    cfl_table #(
        .DEPTH (ENTRIES),
        .AW    (IW)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    cfl_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    assign in_cmd     = t_cmd'(i_in_item.cmd);
    assign full       = (r_count == CW'(ENTRIES));
    assign idx_x      = XW'(i_in_item.entry_index);
    assign cnt_x      = XW'(r_count);
    assign idx_bad    = (idx_x >= cnt_x);
    assign cnt_m1     = r_count - CW'(1);
    assign pos_m1     = r_pos - PW'(1);
    assign pos_m2     = r_pos - PW'(2);
    // Negative difference: stored start lies above the new start
    assign srch_gt    = alu_rsp.sum[SUM_W-1];
    assign srch_last  = (pos_m1 == '0);
    assign mn_eq      = (alu_rsp.sum == SUM_W'(r_next.start));
    assign mp_eq      = (alu_rsp.sum == SUM_W'(r_s));
    assign drop_issue = (r_rd < r_lim);
    assign drop_done  = !drop_issue && !r_pend;
    assign out_free   = !r_ovalid || !i_out_stall;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_item  = r_oitem;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (in_cmd)
                        CMD_INSERT: begin
                            if (full) begin
                                n_state = S_DONE;
                            end else if (r_count == '0) begin
                                n_state = S_MN;
                            end else begin
                                n_state = S_SRCH;
                            end
                        end
                        CMD_REMOVE: n_state = idx_bad ? S_DONE : S_DROP;
                        CMD_UPDATE: n_state = S_DONE;
                        CMD_NOP:    n_state = S_DONE;
                        default:    n_state = S_DONE;
                    endcase
                end
            end
            S_SRCH:  n_state = (srch_gt && !srch_last) ? S_SRCH : S_MN;
            S_MN:    n_state = S_MA;
            S_MA:    n_state = S_MP;
            S_MP:    n_state = S_MB;
            S_MB:    n_state = S_FIN;
            S_FIN:   n_state = (r_mn || r_mp) ? S_DROP : S_DONE;
            S_DROP:  n_state = drop_done ? S_DONE : S_DROP;
            S_DONE:  n_state = out_free ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath, table and unit controls
    always_comb begin
        n_count  = r_count;
        n_s      = r_s;
        n_sz     = r_sz;
        n_pos    = r_pos;
        n_next   = r_next;
        n_prev   = r_prev;
        n_hnext  = r_hnext;
        n_hprev  = r_hprev;
        n_mn     = r_mn;
        n_mp     = r_mp;
        n_a      = r_a;
        n_b      = r_b;
        n_rd     = r_rd;
        n_wr     = r_wr;
        n_lim    = r_lim;
        n_pend   = 1'b0;
        n_cap    = r_cap;
        n_res    = r_res;
        n_ovalid = r_ovalid;
        n_oitem  = r_oitem;
        wr_en    = 1'b0;
        wr_addr  = r_wr[IW-1:0];
        wr_data  = rd_data;
        rd_addr  = r_rd[IW-1:0];
        alu_req  = '{op: ALU_ADD, a: r_sz, b: SIZE_W'(r_next.start)};

        if (r_ovalid && !i_out_stall) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_s              = i_in_item.range_start;
                    n_sz             = i_in_item.range_size;
                    n_res            = '0;
                    n_res.status     = ST_OK;
                    n_res.slot       = i_in_item.entry_index;
                    case (in_cmd)
                        CMD_INSERT: begin
                            if (full) begin
                                n_res.status = ST_FULL;
                                n_res.slot   = '0;
                            end else begin
                                n_pos   = PW'(r_count);
                                n_hnext = 1'b0;
                                n_hprev = 1'b0;
                                rd_addr = cnt_m1[IW-1:0];
                            end
                        end
                        CMD_REMOVE: begin
                            if (idx_bad) begin
                                n_res.status = ST_BAD_INDEX;
                            end else begin
                                n_wr    = PW'(idx_x);
                                n_rd    = PW'(idx_x) + PW'(1);
                                n_lim   = PW'(r_count);
                                n_count = cnt_m1;
                                n_cap   = 1'b1;
                            end
                        end
                        CMD_UPDATE: begin
                            if (idx_bad) begin
                                n_res.status = ST_BAD_INDEX;
                            end else begin
                                wr_en              = 1'b1;
                                wr_addr            = idx_x[IW-1:0];
                                wr_data            = '{start: i_in_item.range_start,
                                                       size: i_in_item.range_size};
                                n_res.result_start = i_in_item.range_start;
                                n_res.result_size  = i_in_item.range_size;
                            end
                        end
                        CMD_NOP: begin
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SRCH: begin
                alu_req = '{op: ALU_SUB, a: SIZE_W'(r_s), b: SIZE_W'(rd_data.start)};
                rd_addr = pos_m2[IW-1:0];
                if (srch_gt) begin
                    // Shift the larger entry up one place and keep walking down
                    wr_en   = 1'b1;
                    wr_addr = r_pos[IW-1:0];
                    wr_data = rd_data;
                    n_next  = rd_data;
                    n_hnext = 1'b1;
                    n_pos   = pos_m1;
                end else begin
                    n_prev  = rd_data;
                    n_hprev = 1'b1;
                end
            end
            S_MN: begin
                // End of the new range against the start of the next entry
                alu_req = '{op: ALU_ADD, a: SIZE_W'(r_s), b: r_sz};
                n_mn    = r_hnext && mn_eq;
            end
            S_MA: begin
                alu_req = '{op: ALU_ADD, a: r_sz, b: r_next.size};
                n_a     = r_mn ? alu_rsp.sat : r_sz;
            end
            S_MP: begin
                alu_req = '{op: ALU_ADD, a: SIZE_W'(r_prev.start), b: r_prev.size};
                n_mp    = r_hprev && mp_eq;
            end
            S_MB: begin
                alu_req = '{op: ALU_ADD, a: r_prev.size, b: r_a};
                n_b     = alu_rsp.sat;
            end
            S_FIN: begin
                n_res.merged_next = r_mn;
                n_res.merged_prev = r_mp;
                n_lim             = PW'(r_count) + PW'(1);
                n_cap             = 1'b0;
                wr_en             = 1'b1;
                if (r_mp) begin
                    // Grow the previous entry; drop the new slot (and next)
                    wr_addr            = pos_m1[IW-1:0];
                    wr_data            = '{start: r_prev.start, size: r_b};
                    n_res.slot         = IDX_W'(pos_m1);
                    n_res.result_start = r_prev.start;
                    n_res.result_size  = r_b;
                    n_wr               = r_pos;
                    if (r_mn) begin
                        n_rd    = r_pos + PW'(2);
                        n_count = cnt_m1;
                    end else begin
                        n_rd    = r_pos + PW'(1);
                    end
                end else if (r_mn) begin
                    wr_addr            = r_pos[IW-1:0];
                    wr_data            = '{start: r_s, size: r_a};
                    n_res.slot         = IDX_W'(r_pos);
                    n_res.result_start = r_s;
                    n_res.result_size  = r_a;
                    n_wr               = r_pos + PW'(1);
                    n_rd               = r_pos + PW'(2);
                end else begin
                    wr_addr            = r_pos[IW-1:0];
                    wr_data            = '{start: r_s, size: r_sz};
                    n_res.slot         = IDX_W'(r_pos);
                    n_res.result_start = r_s;
                    n_res.result_size  = r_sz;
                    n_count            = r_count + CW'(1);
                end
            end
            S_DROP: begin
                rd_addr = r_rd[IW-1:0];
                if (drop_issue) begin
                    n_rd   = r_rd + PW'(1);
                    n_pend = 1'b1;
                end
                if (r_pend) begin
                    wr_en   = 1'b1;
                    wr_addr = r_wr[IW-1:0];
                    wr_data = rd_data;
                    n_wr    = r_wr + PW'(1);
                    // First entry moved down is the one now at the removed index
                    if (r_cap) begin
                        n_res.result_start = rd_data.start;
                        n_res.result_size  = rd_data.size;
                        n_cap              = 1'b0;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_ovalid             = 1'b1;
                    n_oitem              = r_res;
                    n_oitem.entry_total  = TOTAL_W'(r_count);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
            r_pend   <= 1'b0;
            r_cap    <= 1'b0;
            r_hnext  <= 1'b0;
            r_hprev  <= 1'b0;
            r_mn     <= 1'b0;
            r_mp     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
            r_pend   <= n_pend;
            r_cap    <= n_cap;
            r_hnext  <= n_hnext;
            r_hprev  <= n_hprev;
            r_mn     <= n_mn;
            r_mp     <= n_mp;
        end
    end

    always_ff @(posedge i_clk) begin
        r_oitem <= n_oitem;
        r_s     <= n_s;
        r_sz    <= n_sz;
        r_pos   <= n_pos;
        r_next  <= n_next;
        r_prev  <= n_prev;
        r_a     <= n_a;
        r_b     <= n_b;
        r_rd    <= n_rd;
        r_wr    <= n_wr;
        r_lim   <= n_lim;
        r_res   <= n_res;
    end

    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CW'(ENTRIES), "count above depth")
    `ASSERT_IMPLY(a_srch_pos, i_clk, i_rst_n, r_state == S_SRCH, r_pos != '0, "search at bottom")
    `ASSERT_IMPLY(a_drop_order, i_clk, i_rst_n, r_state == S_DROP, r_wr < r_rd, "drop ptr order")
    `ASSERT_IMPLY(a_mp_prev, i_clk, i_rst_n, r_state == S_FIN && r_mp, r_hprev, "merge w/o prev")

endmodule

// File: sv/cfl_alu.sv
// Shared add/subtract unit of the free-range table: sums with saturation
// for merges, signed difference for the sorted search. Uses cfl_pkg.
module cfl_alu (
    input  cfl_pkg::t_alu_req i_req,
    output cfl_pkg::t_alu_rsp o_rsp
);
    import cfl_pkg::*;

    logic [SUM_W-1:0] a_x;
    logic [SUM_W-1:0] b_x;
    logic [SUM_W-1:0] sum;

    assign a_x = SUM_W'(i_req.a);
    assign b_x = SUM_W'(i_req.b);

    always_comb begin
        case (i_req.op)
            ALU_ADD: sum = a_x + b_x;
            ALU_SUB: sum = a_x - b_x;
            default: sum = a_x + b_x;
        endcase
    end

    // Clamp at the largest size on carry out
    assign o_rsp.sum = sum;
    assign o_rsp.sat = sum[SUM_W-1] ? {SIZE_W{1'b1}} : sum[SIZE_W-1:0];

endmodule

// File: sv/cfl_table.sv
// Range storage of the free-range table: one write port, one read port,
// registered read data. Uses cfl_pkg for the entry type.
module cfl_table #(
    parameter int DEPTH = cfl_pkg::ENTRIES_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic            i_clk,
    input  logic            i_wr_en,
    input  logic [AW-1:0]   i_wr_addr,
    input  cfl_pkg::t_entry i_wr_data,
    input  logic [AW-1:0]   i_rd_addr,
    output cfl_pkg::t_entry o_rd_data
);
    import cfl_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule
